@@ src/mvm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, sizes and the microcode ROM for the matrix-vector multiplier.
// No dependencies; used by matrix_vector_multiply and the bench, not by mvm_ram.
package mvm_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int FRAC_BITS = 16;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * DATA_W;
    localparam int ACC_W  = PROD_W + COL_W;
    localparam int MAT_DEPTH = 2 ** (ROW_W + COL_W);
    localparam int VEC_DEPTH = 2 ** COL_W;

    // Count registers are 5 bits wide: keep the limit representable.
    localparam int ROWS_LIMIT = (MAX_ROWS > 31) ? 31 : MAX_ROWS;
    localparam int COLS_LIMIT = (MAX_COLS > 31) ? 31 : MAX_COLS;
    localparam int ROWS_RESET = (16 > ROWS_LIMIT) ? ROWS_LIMIT : 16;
    localparam int COLS_RESET = (16 > COLS_LIMIT) ? COLS_LIMIT : 16;

    localparam longint ROUND_HALF = (FRAC_BITS > 0) ? (64'd1 << (FRAC_BITS - 1)) : 0;

    localparam int APB_AW = 3;

    typedef enum logic [1:0] {
        CMD_LOAD_MAT = 2'd0,
        CMD_LOAD_VEC = 2'd1,
        CMD_COMPUTE  = 2'd2
    } t_cmd;

    typedef enum logic {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } t_reg;

    // Sequencer steps, in program order (fall-through goes to step + 1).
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_ROW    = 3'd1,
        ST_MAC    = 3'd2,
        ST_DRAIN1 = 3'd3,
        ST_DRAIN2 = 3'd4,
        ST_EMIT   = 3'd5
    } t_step;

    typedef enum logic [1:0] {
        J_NEXT = 2'd0,  // fall through
        J_CMD  = 2'd1,  // jump on accepted compute command, else hold
        J_COL  = 2'd2,  // jump while columns remain, else fall through
        J_EMIT = 2'd3   // hold while output busy; jump if rows remain, else idle
    } t_jcond;

    typedef struct packed {
        logic   clr_acc;
        logic   rd_issue;
        logic   emit;
        t_jcond jcond;
        t_step  target;
    } t_uword;

    function automatic t_uword ucode(t_step s);
        t_uword w;
        w = '{clr_acc: 1'b0, rd_issue: 1'b0, emit: 1'b0, jcond: J_NEXT, target: ST_IDLE};
        unique case (s)
            ST_IDLE: begin
                w.jcond  = J_CMD;
                w.target = ST_ROW;
            end
            ST_ROW: begin
                w.clr_acc = 1'b1;
            end
            ST_MAC: begin
                w.rd_issue = 1'b1;
                w.jcond    = J_COL;
                w.target   = ST_MAC;
            end
            ST_DRAIN1, ST_DRAIN2: begin
                w.jcond = J_NEXT;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.jcond  = J_EMIT;
                w.target = ST_ROW;
            end
            default: begin
                w.jcond  = J_EMIT;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ src/mvm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/matrix_vector_multiply.sv @@
`timescale 1ns / 1ps
// Top level of the dense matrix-vector multiplier: microcoded sequencer,
// multiply-accumulate datapath and APB register port. Uses mvm_pkg, mvm_ram.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_stall     | i_command, i_row, i_col, i_value
//  output   | o_out_valid / i_out_stall   | o_out_row, o_out_value, o_overflow, o_last
//  config   | psel, penable, pwrite,      | paddr, pwdata, prdata
//           | pready (always high)        |
//
// Loads are taken back to back while the sequencer is idle. A compute
// transaction runs, per row, one clear step, one multiply-accumulate per column
// through the single matrix RAM read port and shared 32x32 multiplier, two
// pipeline drain steps and one emit step.
// o_in_stall stays high from the compute transaction until the last row leaves
// the sequencer. A stalled output holds the sequencer in its emit step.
// Reset (synchronous, active low) restores both counts to 16 and empties the
// pipeline; matrix and vector contents are not cleared.
module matrix_vector_multiply (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [1:0]                             i_command,
    input  logic [3:0]                             i_row,
    input  logic [3:0]                             i_col,
    input  logic signed [31:0]                     i_value,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [3:0]                             o_out_row,
    output logic signed [31:0]                     o_out_value,
    output logic                                   o_overflow,
    output logic                                   o_last,
    // configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mvm_pkg::APB_AW-1:0]             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mvm_pkg::t_step                          r_step, n_step;
    logic [mvm_pkg::ROW_W-1:0]               r_row, n_row;
    logic [mvm_pkg::COL_W-1:0]               r_col, n_col;
    logic [mvm_pkg::CNT_W-1:0]               r_rows, r_cols;
    logic                                    r_rd_v;
    logic                                    r_prod_v;
    logic signed [mvm_pkg::PROD_W-1:0]       r_prod;
    logic signed [mvm_pkg::ACC_W-1:0]        r_acc;
    logic                                    r_out_valid;
    logic [3:0]                              r_out_row;
    logic signed [31:0]                      r_out_value;
    logic                                    r_out_ovf;
    logic                                    r_out_last;

    mvm_pkg::t_uword                         w_uw;
    logic                                    w_in_acc;
    logic                                    w_is_compute;
    logic                                    w_mat_we;
    logic                                    w_vec_we;
    logic                                    w_last_col;
    logic                                    w_last_row;
    logic                                    w_out_free;
    logic                                    w_fire;
    logic [mvm_pkg::DATA_W-1:0]              w_mat_rdata;
    logic [mvm_pkg::DATA_W-1:0]              w_vec_rdata;
    logic signed [mvm_pkg::ACC_W-1:0]        w_rnd;
    logic signed [mvm_pkg::ACC_W-1:0]        w_shift;
    logic [mvm_pkg::ACC_W-31-1:0]            w_hi;
    logic                                    w_fits;
    logic signed [31:0]                      w_sat;
    logic                                    w_cfg_we;
    logic [mvm_pkg::CNT_W-1:0]               w_cfg_v;
    logic [mvm_pkg::CNT_W-1:0]               w_rows_clamped;
    logic [mvm_pkg::CNT_W-1:0]               w_cols_clamped;

    // ------------------------------------------------------------------
    // Input acceptance: the sequencer only takes transactions while idle
    // ------------------------------------------------------------------
    assign o_in_stall   = (r_step != mvm_pkg::ST_IDLE);
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_is_compute = w_in_acc && (i_command == mvm_pkg::CMD_COMPUTE);
    // Drop loads that point outside the stores.
    assign w_mat_we = w_in_acc && (i_command == mvm_pkg::CMD_LOAD_MAT)
                      && (5'(i_row) < 5'(mvm_pkg::ROWS_LIMIT))
                      && (5'(i_col) < 5'(mvm_pkg::COLS_LIMIT));
    assign w_vec_we = w_in_acc && (i_command == mvm_pkg::CMD_LOAD_VEC)
                      && (5'(i_col) < 5'(mvm_pkg::COLS_LIMIT));

    // ------------------------------------------------------------------
    // Element stores
    // ------------------------------------------------------------------
    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (mvm_pkg::MAT_DEPTH)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (w_mat_we),
        .i_waddr ({i_row[mvm_pkg::ROW_W-1:0], i_col[mvm_pkg::COL_W-1:0]}),
        .i_wdata (i_value),
        .i_raddr ({r_row, r_col}),
        .o_rdata (w_mat_rdata)
    );

    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (mvm_pkg::VEC_DEPTH)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_vec_we),
        .i_waddr (i_col[mvm_pkg::COL_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_col),
        .o_rdata (w_vec_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer: fetch the control word for the current step, then decide
    // the next step from its jump condition.
    // ------------------------------------------------------------------
    assign w_uw       = mvm_pkg::ucode(r_step);
    assign w_last_col = (mvm_pkg::CNT_W'(r_col) == (r_cols - 1'b1));
    assign w_last_row = (mvm_pkg::CNT_W'(r_row) == (r_rows - 1'b1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = w_uw.emit && w_out_free;

    always_comb begin
        n_step = r_step;
        n_row  = r_row;
        n_col  = r_col;
        unique case (w_uw.jcond)
            mvm_pkg::J_NEXT: begin
                n_step = mvm_pkg::t_step'(r_step + 1'b1);
            end
            mvm_pkg::J_CMD: begin
                if (w_is_compute) begin
                    n_step = w_uw.target;
                    n_row  = '0;
                end
            end
            mvm_pkg::J_COL: begin
                n_step = w_last_col ? mvm_pkg::t_step'(r_step + 1'b1) : w_uw.target;
            end
            mvm_pkg::J_EMIT: begin
                // Hold here until the output register can take the row.
                if (w_out_free) begin
                    if (w_last_row) begin
                        n_step = mvm_pkg::ST_IDLE;
                    end else begin
                        n_step = w_uw.target;
                        n_row  = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_step = mvm_pkg::ST_IDLE;
            end
        endcase
        // Column counter: restart at a row, advance with every issued read.
        if (w_uw.clr_acc) begin
            n_col = '0;
        end else if (w_uw.rd_issue) begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= mvm_pkg::ST_IDLE;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_step <= n_step;
            r_row  <= n_row;
            r_col  <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Datapath: RAM read -> multiply -> accumulate
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= w_uw.rd_issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= $signed(w_mat_rdata) * $signed(w_vec_rdata);
        end
        if (w_uw.clr_acc) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + {{(mvm_pkg::ACC_W-mvm_pkg::PROD_W){r_prod[mvm_pkg::PROD_W-1]}},
                              r_prod};
        end
    end

    // Round to nearest (ties up), drop the fraction, saturate to 32 bits.
    assign w_rnd   = r_acc + mvm_pkg::ACC_W'(mvm_pkg::ROUND_HALF);
    assign w_shift = w_rnd >>> mvm_pkg::FRAC_BITS;
    assign w_hi    = w_shift[mvm_pkg::ACC_W-1:31];
    assign w_fits  = (&w_hi) || !(|w_hi);
    assign w_sat   = w_fits ? w_shift[31:0]
                            : (w_shift[mvm_pkg::ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF);

    // ------------------------------------------------------------------
    // Output register: parts the sequencer from the downstream stall
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_row   <= 4'(r_row);
            r_out_value <= w_sat;
            r_out_ovf   <= !w_fits;
            r_out_last  <= w_last_row;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_value = r_out_value;
    assign o_overflow  = r_out_ovf;
    assign o_last      = r_out_last;

    // ------------------------------------------------------------------
    // Configuration registers: counts clamp into 1..limit on write
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_cfg_v  = pwdata[mvm_pkg::CNT_W-1:0];

    always_comb begin
        w_rows_clamped = w_cfg_v;
        w_cols_clamped = w_cfg_v;
        if (w_cfg_v == '0) begin
            w_rows_clamped = mvm_pkg::CNT_W'(1);
            w_cols_clamped = mvm_pkg::CNT_W'(1);
        end
        if (w_cfg_v > mvm_pkg::CNT_W'(mvm_pkg::ROWS_LIMIT)) begin
            w_rows_clamped = mvm_pkg::CNT_W'(mvm_pkg::ROWS_LIMIT);
        end
        if (w_cfg_v > mvm_pkg::CNT_W'(mvm_pkg::COLS_LIMIT)) begin
            w_cols_clamped = mvm_pkg::CNT_W'(mvm_pkg::COLS_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= mvm_pkg::CNT_W'(mvm_pkg::ROWS_RESET);
            r_cols <= mvm_pkg::CNT_W'(mvm_pkg::COLS_RESET);
        end else if (w_cfg_we) begin
            unique case (mvm_pkg::t_reg'(paddr[2]))
                mvm_pkg::REG_ROWS: r_rows <= w_rows_clamped;
                mvm_pkg::REG_COLS: r_cols <= w_cols_clamped;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (mvm_pkg::t_reg'(paddr[2]))
            mvm_pkg::REG_ROWS: prdata = 32'(r_rows);
            mvm_pkg::REG_COLS: prdata = 32'(r_cols);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mvm_pkg::ST_EMIT && r_out_valid && i_out_stall)
        |=> (r_step == mvm_pkg::ST_EMIT))
        else $error("sequencer left emit step while output was stalled");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == mvm_pkg::ST_IDLE) |-> (!r_rd_v && !r_prod_v))
        else $error("products still in flight while idle");

    a_read_from_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> ($past(r_step) == mvm_pkg::ST_MAC))
        else $error("RAM read issued outside multiply-accumulate step");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf)
        |-> (r_out_value == 32'sh7FFFFFFF || r_out_value == 32'sh80000000))
        else $error("overflow flagged on an unsaturated value");

endmodule

@@ bench/mvm_product_checker.sv @@
`timescale 1ns / 1ps
// Checker for matrix_vector_multiply: follows the register port and both channels,
// predicts the row products and compares them. Depends on mvm_pkg.
module mvm_product_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic [1:0]                  i_command,
    input  logic [3:0]                  i_row,
    input  logic [3:0]                  i_col,
    input  logic signed [31:0]          i_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [3:0]                  i_out_row,
    input  logic signed [31:0]          i_out_value,
    input  logic                        i_overflow,
    input  logic                        i_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvm_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    input  logic                        pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output logic [4:0]                  o_rows_in_use,
    output logic [4:0]                  o_cols_in_use
);

    localparam int SUM_W = mvm_pkg::ACC_W + 2;
    localparam logic signed [SUM_W-1:0] SUM_HI = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_LO = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         row;
        logic signed [31:0] value;
        logic               overflow;
        logic               last;
    } t_row_result;

    logic [31:0] matrix_words [mvm_pkg::MAX_ROWS*mvm_pkg::MAX_COLS];
    logic [31:0] vector_words [mvm_pkg::MAX_COLS];
    int          rows_used = mvm_pkg::ROWS_RESET;
    int          cols_used = mvm_pkg::COLS_RESET;
    int          mismatches = 0;
    t_row_result expected_rows [$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_rows_in_use = 5'(mvm_pkg::ROWS_RESET);
        o_cols_in_use = 5'(mvm_pkg::COLS_RESET);
        foreach (matrix_words[k]) matrix_words[k] = '0;
        foreach (vector_words[k]) vector_words[k] = '0;
    end

    // Only the low five bits count; zero means one, anything past the size means the size.
    function automatic int fit_count(logic [31:0] raw, int limit);
        int v;
        v = int'(raw[4:0]);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    // Exact sum of products, round half up to the output fraction, then saturate.
    function automatic t_row_result row_dot_product(int r);
        logic signed [SUM_W-1:0] sum;
        logic signed [63:0]      prod;
        t_row_result             res;
        sum = '0;
        for (int c = 0; c < cols_used; c++) begin
            prod = $signed(matrix_words[r*mvm_pkg::MAX_COLS + c]) * $signed(vector_words[c]);
            sum  = sum + prod;
        end
        sum = sum + SUM_W'(mvm_pkg::ROUND_HALF);
        sum = sum >>> mvm_pkg::FRAC_BITS;
        res.row  = r[3:0];
        res.last = (r == rows_used - 1);
        if (sum > SUM_HI) begin
            res.value    = 32'sh7FFF_FFFF;
            res.overflow = 1'b1;
        end else if (sum < SUM_LO) begin
            res.value    = 32'sh8000_0000;
            res.overflow = 1'b1;
        end else begin
            res.value    = sum[31:0];
            res.overflow = 1'b0;
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_row_result want;
        if (!i_rst_n) begin
            rows_used = mvm_pkg::ROWS_RESET;
            cols_used = mvm_pkg::COLS_RESET;
            expected_rows.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[mvm_pkg::APB_AW-1:2])
                    mvm_pkg::REG_ROWS: rows_used = fit_count(pwdata, mvm_pkg::MAX_ROWS);
                    mvm_pkg::REG_COLS: cols_used = fit_count(pwdata, mvm_pkg::MAX_COLS);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, got row %0d value %h",
                             $time, i_out_row, i_out_value);
                end else begin
                    want = expected_rows.pop_front();
                    if (i_out_row !== want.row)
                        report("row", 32'(want.row), 32'(i_out_row));
                    if (i_out_value !== want.value)
                        report("value", want.value, i_out_value);
                    if (i_overflow !== want.overflow)
                        report("overflow", 32'(want.overflow), 32'(i_overflow));
                    if (i_last !== want.last)
                        report("last", 32'(want.last), 32'(i_last));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_command)
                    mvm_pkg::CMD_LOAD_MAT:
                        matrix_words[i_row*mvm_pkg::MAX_COLS + i_col] = i_value;
                    mvm_pkg::CMD_LOAD_VEC: vector_words[i_col] = i_value;
                    mvm_pkg::CMD_COMPUTE: begin
                        for (int r = 0; r < rows_used; r++)
                            expected_rows.push_back(row_dot_product(r));
                    end
                    default: ;
                endcase
            end
        end
        o_pending     <= expected_rows.size();
        o_rows_in_use <= 5'(rows_used);
        o_cols_in_use <= 5'(cols_used);
        o_fail_count  <= mismatches;
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Top of the matrix_vector_multiply testbench: clock, reset, stimulus and verdict.
// Depends on mvm_pkg, matrix_vector_multiply and mvm_product_checker.
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [1:0] CMD_RESERVED = 2'd3;   // no operation; block must ignore it
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 34;
    // Raw count writes per phase; zero, 31 and 17 exercise the clamping.
    localparam logic [4:0] ROWS_PLAN [PHASES] = '{16, 1, 0, 31, 5, 3, 2, 8};
    localparam logic [4:0] COLS_PLAN [PHASES] = '{2, 1, 31, 0, 3, 9, 17, 4};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [1:0]                  i_command = mvm_pkg::CMD_LOAD_MAT;
    logic [3:0]                  i_row = '0;
    logic [3:0]                  i_col = '0;
    logic signed [31:0]          i_value = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [3:0]                  o_out_row;
    logic signed [31:0]          o_out_value;
    logic                        o_overflow;
    logic                        o_last;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [mvm_pkg::APB_AW-1:0]  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    int                          fail_count;
    int                          pending_rows;
    logic [4:0]                  rows_in_use;
    logic [4:0]                  cols_in_use;

    // Which store entries hold a value; computes never touch anything else.
    bit [mvm_pkg::MAX_ROWS*mvm_pkg::MAX_COLS-1:0] mat_written = '0;
    bit [mvm_pkg::MAX_COLS-1:0]                   vec_written = '0;
    bit                                           pace_on = 1'b1;
    int                                           cycle_count = 0;

    matrix_vector_multiply i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_value (o_out_value),
        .o_overflow  (o_overflow),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mvm_product_checker product_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_row         (i_row),
        .i_col         (i_col),
        .i_value       (i_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_row     (o_out_row),
        .i_out_value   (o_out_value),
        .i_overflow    (o_overflow),
        .i_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending_rows),
        .o_rows_in_use (rows_in_use),
        .o_cols_in_use (cols_in_use)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output back-pressure: stall at random while pacing is on, never otherwise.
    always @(posedge i_clk) begin
        i_out_stall <= pace_on && ($urandom_range(0, 99) < 14);
    end

    // Element values: mostly small Q16.16 numbers, often the extremes, sometimes anything.
    function automatic logic [31:0] pick_element();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
        endcase
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high on return,
    // unless pacing drops it for a gap, so the next transaction can follow back to back; callers drop it before idling.
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] row,
                             input logic [3:0] col, input logic [31:0] value);
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_row      <= row;
        i_col      <= col;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == mvm_pkg::CMD_LOAD_MAT) mat_written[row*mvm_pkg::MAX_COLS + col] = 1'b1;
        if (cmd == mvm_pkg::CMD_LOAD_VEC) vec_written[col] = 1'b1;
        if (pace_on && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected row has come back, then let the
    // sequencer settle. The first edge lets the checker's count
    // of pending rows take in the transaction just accepted.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rows != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup then access cycle; the trailing cycle lets the checker's copy of the
    // counts catch up before stimulus reads it.
    task automatic write_reg(input mvm_pkg::t_reg idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mvm_pkg::APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load any element the product will read that has never been written, then
    // issue the compute transaction with junk in the unused fields.
    task automatic run_product();
        int rows;
        int cols;
        rows = int'(rows_in_use);
        cols = int'(cols_in_use);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                if (!mat_written[r*mvm_pkg::MAX_COLS + c])
                    send_item(mvm_pkg::CMD_LOAD_MAT, 4'(r), 4'(c), pick_element());
        for (int c = 0; c < cols; c++)
            if (!vec_written[c])
                send_item(mvm_pkg::CMD_LOAD_VEC, 4'($urandom), 4'(c), pick_element());
        send_item(mvm_pkg::CMD_COMPUTE, 4'($urandom), 4'($urandom), $urandom);
    endtask

    // One random transaction; loads favor the region the current counts cover.
    task automatic random_item();
        int sel;
        int rows;
        int cols;
        logic [3:0] row;
        logic [3:0] col;
        sel  = $urandom_range(0, 99);
        rows = int'(rows_in_use);
        cols = int'(cols_in_use);
        if ($urandom_range(0, 99) < 70) begin
            row = 4'($urandom_range(0, rows - 1));
            col = 4'($urandom_range(0, cols - 1));
        end else begin
            row = 4'($urandom);
            col = 4'($urandom);
        end
        if (sel < 40) send_item(mvm_pkg::CMD_LOAD_MAT, row, col, pick_element());
        else if (sel < 62) send_item(mvm_pkg::CMD_LOAD_VEC, row, col, pick_element());
        else if (sel < 92) run_product();
        else send_item(CMD_RESERVED, 4'($urandom), 4'($urandom), $urandom);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Saturation both ways: full-scale operands over two columns.
        write_reg(mvm_pkg::REG_ROWS, 32'd2);
        write_reg(mvm_pkg::REG_COLS, 32'd2);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd1, 4'd0, 32'h8000_0000);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd1, 4'd1, 32'h8000_0000);
        send_item(mvm_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_item(mvm_pkg::CMD_LOAD_VEC, 4'd0, 4'd1, 32'h7FFF_FFFF);
        send_item(mvm_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);
        wait_idle();

        // Rounding ties: +half rounds up to one LSB, -half rounds up to zero.
        write_reg(mvm_pkg::REG_COLS, 32'd1);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd0, 4'd0, 32'h0000_0001);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd1, 4'd0, 32'hFFFF_FFFF);
        send_item(mvm_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'h0000_8000);
        send_item(mvm_pkg::CMD_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);

        // Plain fixed-point products, a reserved command that must do nothing,
        // and the highest indexes of both stores.
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd0, 4'd0, 32'h0001_8000);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd1, 4'd0, 32'hFFFF_0000);
        send_item(mvm_pkg::CMD_LOAD_VEC, 4'd0, 4'd0, 32'h0001_0000);
        send_item(CMD_RESERVED, 4'd1, 4'd0, 32'h1234_5678);
        send_item(mvm_pkg::CMD_LOAD_MAT, 4'd15, 4'd15, 32'h8000_0000);
        send_item(mvm_pkg::CMD_LOAD_VEC, 4'd15, 4'd15, 32'h7FFF_FFFF);
        send_item(mvm_pkg::CMD_COMPUTE, 4'd0, 4'd0, 32'h0);

        // Random phases, each under its own pair of counts. Odd phases put junk in
        // the upper data bits, which the count registers must ignore. Phases three
        // and four run with no gaps and no stalls on either side.
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            pace_on = !(p == 3 || p == 4);
            if (p % 2 == 1) begin
                write_reg(mvm_pkg::REG_ROWS, {27'($urandom), ROWS_PLAN[p]});
                write_reg(mvm_pkg::REG_COLS, {27'($urandom), COLS_PLAN[p]});
            end else begin
                write_reg(mvm_pkg::REG_ROWS, {27'd0, ROWS_PLAN[p]});
                write_reg(mvm_pkg::REG_COLS, {27'd0, COLS_PLAN[p]});
            end
            repeat (PHASE_ITEMS) random_item();
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
